/* rtl/pprb_pkg.sv */
// Shared types and codes for the per-peer packet reorder buffer.
`default_nettype none
package pprb_pkg;
	localparam logic [1:0] ACT_ARRIVE = 2'd0;
	localparam logic [1:0] ACT_POLL   = 2'd1;
	localparam logic [1:0] ACT_FLUSH  = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	localparam logic [2:0] KIND_DELIVER = 3'd0;
	localparam logic [2:0] KIND_PASS    = 3'd1;
	localparam logic [2:0] KIND_BUF     = 3'd2;
	localparam logic [2:0] KIND_DUP     = 3'd3;
	localparam logic [2:0] KIND_EVICT   = 3'd4;
	localparam logic [2:0] KIND_NONE    = 3'd5;
	localparam logic [2:0] KIND_FLUSH   = 3'd6;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_PEERS  = 2'd1;
	localparam logic [1:0] REG_SLOTS  = 2'd2;
	localparam logic [1:0] REG_MINLEN = 2'd3;

	localparam int KEY_PORT_BITS = 16;

	typedef struct packed {
		logic [31:0] seq;
		logic [47:0] tstamp;
		logic [15:0] tag;
		logic [11:0] len;
	} slot_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] tag;
		logic [11:0] len;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] seq;
		logic [15:0] evicted;
	} res_t;
endpackage
`default_nettype wire

/* rtl/pprb_min_tree.sv */
// Balanced min-search tree: lowest key among enabled leaves, lowest index on ties.
`default_nettype none
module pprb_min_tree import pprb_pkg::*; #(
	parameter int N = 16,
	parameter int W = 48
) (
	input  wire logic [N-1:0]              en,
	input  wire logic [W-1:0]              key [N],
	output logic                           found,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int M  = 1 << $clog2(N);

	logic          v  [2*M];
	logic [W-1:0]  k  [2*M];
	logic [IW-1:0] ix [2*M];

	always_comb begin
		v[0]  = 1'b0;
		k[0]  = '0;
		ix[0] = '0;
		for (int i = 0; i < M; i++) begin
			if (i < N) begin
				v[M+i]  = en[i];
				k[M+i]  = key[i];
			end else begin
				v[M+i]  = 1'b0;
				k[M+i]  = '0;
			end
			ix[M+i] = IW'(i);
		end
		for (int n = M - 1; n >= 1; n--) begin
			// take the right child only when it is strictly smaller
			if (v[2*n+1] && (!v[2*n] || k[2*n+1] < k[2*n])) begin
				v[n]  = 1'b1;
				k[n]  = k[2*n+1];
				ix[n] = ix[2*n+1];
			end else begin
				v[n]  = v[2*n];
				k[n]  = k[2*n];
				ix[n] = ix[2*n];
			end
		end
		found = v[1];
		idx   = ix[1];
	end
endmodule
`default_nettype wire

/* rtl/per_peer_packet_reorder_buffer_unit.sv */
// Per-peer packet reorder buffer: peer table, slot row memory and control sequencer.
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction: an arrival, a poll or
//   a flush. Output channel (out_valid/out_ready) returns one result per
//   transaction; action code 3 returns none. Registers are to be written over
//   the APB port while the block is idle; the block itself does not enforce this.
//   pready is tied high. One transaction is processed at a time. Each peer owns
//   one row of the slot memory (registered read); the row is read, compared
//   across all slots in parallel and, for an arrival that is not a duplicate,
//   written back. A poll visits the peers in order, skipping free or empty ones
//   and searching the row of each other one until a slot is picked.
//   Reset clears the peer table and all slot valid bits and loads the register
//   defaults; the memory needs no clearing pass.
//   A finished result sits in the output register; a stalled receiver holds it
//   there, and in_ready stays low until the next result has a place to go.
`default_nettype none
module per_peer_packet_reorder_buffer_unit import pprb_pkg::*; #(
	parameter int PEERS         = 8,
	parameter int SLOTS         = 16,
	parameter int MAX_PKT_BYTES = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] src_addr,
	input  wire logic [15:0] src_port,
	input  wire logic        is_ipv4,
	input  wire logic [31:0] seq,
	input  wire logic [15:0] pkt_tag,
	input  wire logic [11:0] pkt_len,
	input  wire logic [47:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      out_tag,
	output logic [11:0]      out_len,
	output logic [31:0]      out_addr,
	output logic [15:0]      out_port,
	output logic [31:0]      out_seq,
	output logic [15:0]      evicted_tag
);
	localparam int PW = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = $clog2(SLOTS + 1);
	localparam int CW = $clog2(PEERS + 1);
	localparam logic [16:0] MAXLEN = 17'(MAX_PKT_BYTES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AFND = 3'd1;
	localparam logic [2:0] S_AEV  = 3'd2;
	localparam logic [2:0] S_PRD  = 3'd3;
	localparam logic [2:0] S_PEV  = 3'd4;
	localparam logic [2:0] S_PSEL = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	// configuration
	logic [15:0] win_q;
	logic [3:0]  peers_q;
	logic [4:0]  slots_q;
	logic [11:0] minp_q;

	// peer table
	logic [47:0]    pkey_q  [PEERS];
	logic [31:0]    plast_q [PEERS];
	logic           psv_q   [PEERS];
	logic [FW-1:0]  fill_q  [PEERS];
	logic [SLOTS-1:0] sv_q  [PEERS];

	// slot memory, one row per peer
	slot_t [SLOTS-1:0] mem [PEERS];
	slot_t [SLOTS-1:0] rd_row_s1;
	slot_t [SLOTS-1:0] new_row;
	logic              rd_en;
	logic [PW-1:0]     rd_addr;
	logic              wr_en;

	// control
	logic [2:0]    state_q;
	logic [PW-1:0] pi_q;
	res_t          pend_q;
	res_t          res_q;
	logic          out_valid_q;

	// latched transaction
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic        ipv4_q;
	logic [31:0] seq_q;
	logic [15:0] tag_q;
	logic [11:0] len_q;
	logic [47:0] now_q;

	// poll search stage
	logic [SLOTS-1:0] exact_q;
	logic [SLOTS-1:0] ahead_en_q;
	logic [SLOTS-1:0] old_en_q;
	logic [31:0]      dist_q [SLOTS];

	logic [CW-1:0]    np;
	logic [FW-1:0]    ns;
	logic [SLOTS-1:0] slot_en;
	logic [47:0]      key_in;
	logic [11:0]      clen;
	logic             elig;
	logic             hit, free_f;
	logic [PW-1:0]    hit_idx, free_idx, fa_idx;
	logic             last_p, skip_p;

	logic [SLOTS-1:0] vld;
	logic             dup;
	logic             sfree_f;
	logic [SW-1:0]    sfree_idx;
	logic [SW-1:0]    ins_idx;

	logic [31:0]      want;
	logic [SLOTS-1:0] exact_c, ahead_c, old_c;
	logic [31:0]      dist_c [SLOTS];
	logic [47:0]      diff;

	logic [47:0]      times [SLOTS];
	logic [SLOTS-1:0] tree_en;
	logic             old_f, ahead_f, ex_f;
	logic [SW-1:0]    old_idx, ahead_idx, ex_idx, pick_idx;
	logic             pick_f;

	assign pready    = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign kind        = res_q.kind;
	assign out_tag     = res_q.tag;
	assign out_len     = res_q.len;
	assign out_addr    = res_q.addr;
	assign out_port    = res_q.port;
	assign out_seq     = res_q.seq;
	assign evicted_tag = res_q.evicted;

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW: prdata = {16'd0, win_q};
			REG_PEERS:  prdata = {28'd0, peers_q};
			REG_SLOTS:  prdata = {27'd0, slots_q};
			REG_MINLEN: prdata = {20'd0, minp_q};
			default:    prdata = '0;
		endcase
	end

	// saturated counts and static per-transaction terms
	always_comb begin
		if (peers_q == 4'd0)
			np = CW'(1);
		else if (int'(peers_q) > PEERS)
			np = CW'(PEERS);
		else
			np = CW'(peers_q);
		if (slots_q == 5'd0)
			ns = FW'(1);
		else if (int'(slots_q) > SLOTS)
			ns = FW'(SLOTS);
		else
			ns = FW'(slots_q);
		for (int i = 0; i < SLOTS; i++)
			slot_en[i] = (i < int'(ns));
		key_in = {addr_q, port_q};
		clen   = ({5'd0, len_q} > MAXLEN) ? MAXLEN[11:0] : len_q;
		elig   = ipv4_q && (len_q >= minp_q);
		last_p = (int'(pi_q) >= int'(np) - 1);
		skip_p = (pkey_q[pi_q] == 48'd0) || (fill_q[pi_q] == '0);
	end

	// peer lookup: match first, then first free entry
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_f   = 1'b0;
		free_idx = '0;
		for (int i = 0; i < PEERS; i++) begin
			if (i < int'(np) && !hit && pkey_q[i] == key_in) begin
				hit     = 1'b1;
				hit_idx = PW'(i);
			end
			if (i < int'(np) && !free_f && pkey_q[i] == 48'd0) begin
				free_f   = 1'b1;
				free_idx = PW'(i);
			end
		end
		fa_idx = hit ? hit_idx : free_idx;
	end

	// arrival evaluation on the row just read
	always_comb begin
		vld       = sv_q[pi_q] & slot_en;
		dup       = 1'b0;
		sfree_f   = 1'b0;
		sfree_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			times[i] = rd_row_s1[i].tstamp;
			if (vld[i] && rd_row_s1[i].seq == seq_q)
				dup = 1'b1;
			if (slot_en[i] && !sv_q[pi_q][i] && !sfree_f) begin
				sfree_f   = 1'b1;
				sfree_idx = SW'(i);
			end
		end
		ins_idx = sfree_f ? sfree_idx : old_idx;
		new_row = rd_row_s1;
		new_row[ins_idx] = '{seq: seq_q, tstamp: now_q, tag: tag_q, len: clen};
	end

	// poll: per-slot flags ahead of the trees
	always_comb begin
		want = plast_q[pi_q] + 32'd1;
		for (int i = 0; i < SLOTS; i++) begin
			diff      = now_q - rd_row_s1[i].tstamp;
			dist_c[i] = rd_row_s1[i].seq - want;
			exact_c[i] = psv_q[pi_q] && vld[i] && rd_row_s1[i].seq == want;
			old_c[i]   = vld[i] && (!psv_q[pi_q] ||
				(now_q >= rd_row_s1[i].tstamp && diff >= {32'd0, win_q}));
			ahead_c[i] = psv_q[pi_q] && old_c[i] && !dist_c[i][31];
		end
	end

	always_comb begin
		ex_f   = 1'b0;
		ex_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (exact_q[i] && !ex_f) begin
				ex_f   = 1'b1;
				ex_idx = SW'(i);
			end
		end
		tree_en = (state_q == S_AEV) ? vld : old_en_q;
		pick_f  = ex_f || ahead_f || old_f;
		if (ex_f)
			pick_idx = ex_idx;
		else if (ahead_f)
			pick_idx = ahead_idx;
		else
			pick_idx = old_idx;
	end

	pprb_min_tree #(.N(SLOTS), .W(48)) u_old_tree (
		.en    (tree_en),
		.key   (times),
		.found (old_f),
		.idx   (old_idx)
	);

	pprb_min_tree #(.N(SLOTS), .W(32)) u_ahead_tree (
		.en    (ahead_en_q),
		.key   (dist_q),
		.found (ahead_f),
		.idx   (ahead_idx)
	);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pi_q;
		if (state_q == S_AFND && elig && (hit || free_f)) begin
			rd_en   = 1'b1;
			rd_addr = fa_idx;
		end else if (state_q == S_PRD && !skip_p) begin
			rd_en = 1'b1;
		end
		wr_en = (state_q == S_AEV) && !dup;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[pi_q] <= new_row;
		if (rd_en)
			rd_row_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= 16'd20;
			peers_q     <= 4'd8;
			slots_q     <= 5'd16;
			minp_q      <= 12'd4;
			state_q     <= S_IDLE;
			pi_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PEERS; i++) begin
				pkey_q[i]  <= '0;
				plast_q[i] <= '0;
				psv_q[i]   <= 1'b0;
				fill_q[i]  <= '0;
				sv_q[i]    <= '0;
			end
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_WINDOW: win_q   <= pwdata[15:0];
					REG_PEERS:  peers_q <= pwdata[3:0];
					REG_SLOTS:  slots_q <= pwdata[4:0];
					REG_MINLEN: minp_q  <= pwdata[11:0];
					default:    win_q   <= win_q;
				endcase
			end
			// the output state reloads the register itself
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						addr_q <= src_addr;
						port_q <= src_port;
						ipv4_q <= is_ipv4;
						seq_q  <= seq;
						tag_q  <= pkt_tag;
						len_q  <= pkt_len;
						now_q  <= now_ms;
						pi_q   <= '0;
						case (action)
							ACT_ARRIVE: state_q <= S_AFND;
							ACT_POLL:   state_q <= S_PRD;
							ACT_FLUSH: begin
								for (int i = 0; i < PEERS; i++) begin
									pkey_q[i]  <= '0;
									plast_q[i] <= '0;
									psv_q[i]   <= 1'b0;
									fill_q[i]  <= '0;
									sv_q[i]    <= '0;
								end
								pend_q  <= '{kind: KIND_FLUSH, default: '0};
								state_q <= S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_AFND: begin
					if (elig && (hit || free_f)) begin
						pi_q <= fa_idx;
						if (!hit) begin
							pkey_q[fa_idx]  <= key_in;
							plast_q[fa_idx] <= '0;
							psv_q[fa_idx]   <= 1'b0;
							fill_q[fa_idx]  <= '0;
							sv_q[fa_idx]    <= '0;
						end
						state_q <= S_AEV;
					end else begin
						pend_q <= '{kind: KIND_PASS, tag: tag_q, len: clen, addr: addr_q,
							port: port_q, seq: 32'd0, evicted: 16'd0};
						state_q <= S_OUT;
					end
				end
				S_AEV: begin
					if (dup) begin
						pend_q <= '{kind: KIND_DUP, tag: tag_q, default: '0};
					end else if (sfree_f) begin
						sv_q[pi_q][sfree_idx] <= 1'b1;
						fill_q[pi_q]          <= fill_q[pi_q] + FW'(1);
						pend_q                <= '{kind: KIND_BUF, default: '0};
					end else begin
						pend_q <= '{kind: KIND_EVICT, evicted: rd_row_s1[old_idx].tag,
							default: '0};
					end
					state_q <= S_OUT;
				end
				S_PRD: begin
					if (!skip_p) begin
						state_q <= S_PEV;
					end else if (last_p) begin
						pend_q  <= '{kind: KIND_NONE, default: '0};
						state_q <= S_OUT;
					end else begin
						pi_q <= pi_q + PW'(1);
					end
				end
				S_PEV: begin
					exact_q    <= exact_c;
					ahead_en_q <= ahead_c;
					old_en_q   <= old_c;
					for (int i = 0; i < SLOTS; i++)
						dist_q[i] <= dist_c[i];
					state_q <= S_PSEL;
				end
				S_PSEL: begin
					if (pick_f) begin
						pend_q <= '{kind: KIND_DELIVER, tag: rd_row_s1[pick_idx].tag,
							len: rd_row_s1[pick_idx].len,
							addr: pkey_q[pi_q][47:KEY_PORT_BITS],
							port: pkey_q[pi_q][KEY_PORT_BITS-1:0],
							seq: rd_row_s1[pick_idx].seq, evicted: 16'd0};
						plast_q[pi_q]        <= rd_row_s1[pick_idx].seq;
						psv_q[pi_q]          <= 1'b1;
						sv_q[pi_q][pick_idx] <= 1'b0;
						fill_q[pi_q]         <= fill_q[pi_q] - FW'(1);
						state_q              <= S_OUT;
					end else if (last_p) begin
						pend_q  <= '{kind: KIND_NONE, default: '0};
						state_q <= S_OUT;
					end else begin
						pi_q    <= pi_q + PW'(1);
						state_q <= S_PRD;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						res_q       <= pend_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* test/per_peer_packet_reorder_buffer_unit_tb.sv */
// Self-checking testbench for the per-peer packet reorder buffer unit.
`timescale 1ns / 100ps
module per_peer_packet_reorder_buffer_unit_tb;
	import pprb_pkg::*;

	localparam int NPEER = 8;
	localparam int NSLOT = 16;
	localparam int MAXLEN = 2048;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] addr;
		logic [15:0] port;
		logic        v4;
		logic [31:0] sq;
		logic [15:0] tag;
		logic [11:0] len;
		logic [47:0] now;
	} pkt_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] action;
	logic [31:0] src_addr;
	logic [15:0] src_port;
	logic is_ipv4;
	logic [31:0] seq;
	logic [15:0] pkt_tag;
	logic [11:0] pkt_len;
	logic [47:0] now_ms;
	logic out_valid, out_ready;
	logic [2:0] kind;
	logic [15:0] out_tag;
	logic [11:0] out_len;
	logic [31:0] out_addr;
	logic [15:0] out_port;
	logic [31:0] out_seq;
	logic [15:0] evicted_tag;

	per_peer_packet_reorder_buffer_unit i_dut (.*);

	// predictor state
	logic [15:0] win_ms;
	logic [3:0]  peer_cnt;
	logic [4:0]  slot_cnt;
	logic [11:0] min_len;
	logic [47:0] pk_key [NPEER];
	logic [31:0] pk_last [NPEER];
	logic        pk_seen [NPEER];
	logic [4:0]  pk_fill [NPEER];
	logic        sl_vld [NPEER][NSLOT];
	slot_t       sl [NPEER][NSLOT];

	res_t pending_res[$];
	int   errors = 0;
	logic [47:0] clock_ms = 48'd1000;

	function automatic int peers_eff();
		return (peer_cnt < 1) ? 1 : (peer_cnt > NPEER) ? NPEER : peer_cnt;
	endfunction

	function automatic int slots_eff();
		return (slot_cnt < 1) ? 1 : (slot_cnt > NSLOT) ? NSLOT : slot_cnt;
	endfunction

	task automatic wipe_all();
		for (int p = 0; p < NPEER; p++) begin
			pk_key[p] = '0; pk_last[p] = '0; pk_seen[p] = 0; pk_fill[p] = '0;
			for (int s = 0; s < NSLOT; s++) begin
				sl_vld[p][s] = 0;
				sl[p][s] = '0;
			end
		end
	endtask

	function automatic int choose_slot(int p, logic [47:0] t);
		int ns, oldest, ahead;
		logic [31:0] want, d, bestd;
		ns = slots_eff();
		oldest = -1;
		ahead = -1;
		bestd = '0;
		if (pk_fill[p] == 0) return -1;
		if (pk_seen[p]) begin
			want = pk_last[p] + 32'd1;
			for (int i = 0; i < ns; i++)
				if (sl_vld[p][i] && sl[p][i].seq == want) return i;
			for (int i = 0; i < ns; i++) begin
				if (!sl_vld[p][i]) continue;
				if (t < sl[p][i].tstamp || t - sl[p][i].tstamp < {32'd0, win_ms}) continue;
				if (oldest < 0 || sl[p][i].tstamp < sl[p][oldest].tstamp) oldest = i;
				d = sl[p][i].seq - want;
				if (d < 32'h8000_0000 && (ahead < 0 || d < bestd)) begin
					ahead = i;
					bestd = d;
				end
			end
			return (ahead >= 0) ? ahead : oldest;
		end
		for (int i = 0; i < ns; i++)
			if (sl_vld[p][i] && (oldest < 0 || sl[p][i].tstamp < sl[p][oldest].tstamp))
				oldest = i;
		return oldest;
	endfunction

	// Compute the reorder buffer's response and update its mirrored state.
	task automatic predict_reorder(input pkt_t x, output res_t r, output bit has);
		logic [47:0] key;
		logic [11:0] clen;
		int pi, ns, s, oix;
		r = '0;
		has = 1;
		ns = slots_eff();
		if (x.act == ACT_NOP) begin
			has = 0;
			return;
		end
		if (x.act == ACT_FLUSH) begin
			wipe_all();
			r.kind = KIND_FLUSH;
			return;
		end
		if (x.act == ACT_POLL) begin
			for (int p = 0; p < peers_eff(); p++) begin
				if (pk_key[p] == 0) continue;
				s = choose_slot(p, x.now);
				if (s < 0) continue;
				r.kind = KIND_DELIVER;
				r.tag = sl[p][s].tag;
				r.len = sl[p][s].len;
				r.addr = pk_key[p][47:16];
				r.port = pk_key[p][15:0];
				r.seq = sl[p][s].seq;
				pk_last[p] = sl[p][s].seq;
				pk_seen[p] = 1;
				sl_vld[p][s] = 0;
				if (pk_fill[p] > 0) pk_fill[p]--;
				return;
			end
			r.kind = KIND_NONE;
			return;
		end
		key = {x.addr, x.port};
		clen = (x.len > MAXLEN) ? MAXLEN[11:0] : x.len;
		pi = -1;
		if (x.v4 && x.len >= min_len) begin
			for (int p = 0; p < peers_eff() && pi < 0; p++)
				if (pk_key[p] == key) pi = p;
			for (int p = 0; p < peers_eff() && pi < 0; p++)
				if (pk_key[p] == 0) begin
					pi = p;
					pk_key[p] = key; pk_last[p] = '0; pk_seen[p] = 0; pk_fill[p] = '0;
					for (int i = 0; i < NSLOT; i++) begin
						sl_vld[p][i] = 0;
						sl[p][i] = '0;
					end
				end
		end
		if (pi < 0) begin
			r.kind = KIND_PASS; r.tag = x.tag; r.len = clen; r.addr = x.addr; r.port = x.port;
			return;
		end
		for (int i = 0; i < ns; i++)
			if (sl_vld[pi][i] && sl[pi][i].seq == x.sq) begin
				r.kind = KIND_DUP;
				r.tag = x.tag;
				return;
			end
		for (int i = 0; i < ns; i++)
			if (!sl_vld[pi][i]) begin
				sl_vld[pi][i] = 1;
				sl[pi][i] = '{x.sq, x.now, x.tag, clen};
				pk_fill[pi]++;
				r.kind = KIND_BUF;
				return;
			end
		oix = 0;
		for (int i = 1; i < ns; i++)
			if (sl_vld[pi][i] && sl[pi][i].tstamp < sl[pi][oix].tstamp) oix = i;
		r.kind = KIND_EVICT;
		r.evicted = sl[pi][oix].tag;
		sl_vld[pi][oix] = 1;
		sl[pi][oix] = '{x.sq, x.now, x.tag, clen};
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result kind=%0d", $time, kind);
				errors++;
			end else begin
				e = pending_res.pop_front();
				if ({kind, out_tag, out_len, out_addr, out_port, out_seq, evicted_tag} !== e) begin
					$display("%0t: mismatch expected %h actual %h", $time, e,
						{kind, out_tag, out_len, out_addr, out_port, out_seq, evicted_tag});
					errors++;
				end
			end
		end
	end

	// Random receiver stall.
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = $urandom_range(0, 99);
			if (g < 60) out_ready <= 1;
			else if (g < 95) out_ready <= 0;
			else begin
				out_ready <= 0;
				repeat ($urandom_range(5, 40)) @(posedge clk);
				out_ready <= 1;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_WINDOW: win_ms = val[15:0];
			REG_PEERS:  peer_cnt = val[3:0];
			REG_SLOTS:  slot_cnt = val[4:0];
			default:    min_len = val[11:0];
		endcase
	endtask

	task automatic drain_wait();
		in_valid <= 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Send one transaction; expectation is queued when it is accepted.
	// Valid stays high into the next transaction unless a gap is taken.
	task automatic send_pkt(input pkt_t x, input bit chk, input res_t want);
		res_t r;
		bit has;
		int g;
		g = $urandom_range(0, 99);
		if (g < 20) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end else if (g < 23) begin
			in_valid <= 0;
			repeat ($urandom_range(10, 60)) @(posedge clk);
		end
		in_valid <= 1;
		{action, src_addr, src_port, is_ipv4, seq, pkt_tag, pkt_len, now_ms} <= x;
		do @(posedge clk); while (!in_ready);
		predict_reorder(x, r, has);
		if (chk && has && r !== want) begin
			$display("%0t: table row expected %h predictor %h", $time, want, r);
			errors++;
		end
		if (has) pending_res.push_back(r);
	endtask

	function automatic pkt_t mk(logic [1:0] a, logic [31:0] ad, logic [15:0] pt,
			logic v, logic [31:0] s, logic [15:0] tg, logic [11:0] l, logic [47:0] t);
		return '{a, ad, pt, v, s, tg, l, t};
	endfunction

	function automatic res_t rs(logic [2:0] k, logic [15:0] tg, logic [11:0] l,
			logic [31:0] ad, logic [15:0] pt, logic [31:0] s);
		return '{k, tg, l, ad, pt, s, 16'd0};
	endfunction

	pkt_t dir_pkt [$];
	bit   dir_chk [$];
	res_t dir_res [$];

	task automatic row(input pkt_t x, input bit c, input res_t r);
		dir_pkt.push_back(x); dir_chk.push_back(c); dir_res.push_back(r);
	endtask

	initial begin
		pkt_t x;
		int np, base, n;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; action = '0; src_addr = '0; src_port = '0; is_ipv4 = 0;
		seq = '0; pkt_tag = '0; pkt_len = '0; now_ms = '0;
		win_ms = 16'd20; peer_cnt = 4'd8; slot_cnt = 5'd16; min_len = 12'd4;
		wipe_all();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 0), 1, rs(KIND_NONE, 0, 0, 0, 0, 0));
		row(mk(ACT_ARRIVE, 32'hFFFF_FFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 16'hFFFF, 12'hFFF,
			48'hFFFF_FFFF_FFFF), 1,
			rs(KIND_PASS, 16'hFFFF, 12'd2048, 32'hFFFF_FFFF, 16'hFFFF, 0));
		row(mk(ACT_ARRIVE, 32'h0A00_0001, 16'd5000, 1, 7, 16'h1234, 12'd3, 100), 1,
			rs(KIND_PASS, 16'h1234, 12'd3, 32'h0A00_0001, 16'd5000, 0));
		row(mk(ACT_ARRIVE, 32'h0A00_0001, 16'd5000, 1, 10, 16'hA, 12'hFFF, 100), 0, '0);
		row(mk(ACT_ARRIVE, 32'h0A00_0001, 16'd5000, 1, 10, 16'hB, 12'd10, 101), 1,
			rs(KIND_DUP, 16'hB, 0, 0, 0, 0));
		row(mk(ACT_ARRIVE, 32'h0A00_0001, 16'd5000, 1, 12, 16'hC, 12'd10, 102), 0, '0);
		row(mk(ACT_ARRIVE, 32'h0A00_0001, 16'd5000, 1, 11, 16'hD, 12'd10, 103), 0, '0);
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 104), 1,
			rs(KIND_DELIVER, 16'hA, 12'd2048, 32'h0A00_0001, 16'd5000, 10));
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 104), 0, '0);
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 104), 0, '0);
		row(mk(ACT_ARRIVE, 0, 0, 1, 5, 16'hE, 12'd8, 200), 0, '0);
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 201), 0, '0);
		row(mk(ACT_ARRIVE, 32'h0A00_0002, 16'd1, 1, 32'hFFFF_FFFF, 16'hF, 12'd0, 300), 0, '0);
		row(mk(ACT_ARRIVE, 32'h0A00_0002, 16'd1, 1, 50, 16'h10, 12'd9, 48'hFFFF_FFFF_FFFF),
			0, '0);
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 400), 0, '0);
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 400), 0, '0);
		row(mk(ACT_NOP, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		row(mk(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1, rs(KIND_FLUSH, 0, 0, 0, 0, 0));
		row(mk(ACT_POLL, 0, 0, 0, 0, 0, 0, 0), 1, rs(KIND_NONE, 0, 0, 0, 0, 0));
		for (int i = 0; i < dir_pkt.size(); i++) send_pkt(dir_pkt[i], dir_chk[i], dir_res[i]);
		drain_wait();

		// eviction and full peer table
		reg_write(REG_SLOTS, 2);
		reg_write(REG_PEERS, 1);
		reg_write(REG_MINLEN, 0);
		for (int i = 0; i < 4; i++)
			send_pkt(mk(ACT_ARRIVE, 32'h0B00_0000, 16'd9, 1, i, i, 12'd20, 10 + i), 0, '0);
		send_pkt(mk(ACT_ARRIVE, 32'h0C00_0000, 16'd9, 1, 1, 16'h55, 12'd20, 20), 1,
			rs(KIND_PASS, 16'h55, 12'd20, 32'h0C00_0000, 16'd9, 0));
		drain_wait();

		// out-of-range register values and extremes
		reg_write(REG_PEERS, 0);
		reg_write(REG_SLOTS, 5'd31);
		reg_write(REG_WINDOW, 16'hFFFF);
		reg_write(REG_MINLEN, 12'd2048);
		for (int i = 0; i < 8; i++)
			send_pkt(mk($urandom_range(0, 1), $urandom, $urandom, 1, $urandom,
				$urandom, $urandom_range(2040, 4095), $urandom), 0, '0);
		drain_wait();
		reg_write(REG_PEERS, 15);
		reg_write(REG_SLOTS, 0);
		reg_write(REG_WINDOW, 0);
		reg_write(REG_MINLEN, 12'hFFF);
		send_pkt(mk(ACT_ARRIVE, 1, 1, 1, 1, 1, 12'hFFF, 1), 0, '0);
		drain_wait();

		// random phases
		for (int ph = 0; ph < 7; ph++) begin
			reg_write(REG_WINDOW, (ph == 0) ? 0 : $urandom_range(0, 40));
			reg_write(REG_PEERS, $urandom_range(1, 8));
			reg_write(REG_SLOTS, (ph == 1) ? 16 : $urandom_range(1, 16));
			reg_write(REG_MINLEN, $urandom_range(0, 8));
			np = $urandom_range(2, 9);
			base = $urandom;
			for (int it = 0; it < 250; it++) begin
				n = $urandom_range(0, 99);
				clock_ms += $urandom_range(0, 6);
				x = mk(ACT_ARRIVE, 32'hC0A8_0000 + base + $urandom_range(0, np - 1),
					16'd4000 + $urandom_range(0, 1), 1, 32'hFFFF_FFF0 + $urandom_range(0, 40),
					$urandom, $urandom_range(0, 64), clock_ms);
				if (n < 35) x.act = ACT_POLL;
				else if (n < 37) x.act = ACT_FLUSH;
				else if (n < 38) x.act = ACT_NOP;
				else if (n < 44) begin
					x.addr = $urandom; x.port = $urandom; x.v4 = $urandom;
					x.sq = $urandom; x.len = $urandom_range(0, 4095);
					x.now = (n == 40) ? {$urandom, $urandom} : clock_ms;
				end else if (n < 46) begin
					x.now = clock_ms - $urandom_range(0, 50);
				end
				send_pkt(x, 0, '0);
				if (ph == 3 && it == 120) drain_wait();
			end
			drain_wait();
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
